// ===== hdl/ptiqr_pkg.sv =====
// ----------------------------------------------------------------------------
// ptiqr_pkg
// Shared widths, operation codes and status codes of the task input queue
// router.
// ----------------------------------------------------------------------------
package ptiqr_pkg;

    localparam int OP_W   = 3;
    localparam int TASK_W = 4;
    localparam int BYTE_W = 8;
    localparam int ST_W   = 2;

    localparam int DEF_NUM_TASKS   = 16;
    localparam int DEF_QUEUE_DEPTH = 64;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [TASK_W-1:0] t_task;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [ST_W-1:0]   t_status;

    localparam t_op OP_PUSH_FOCUS = 3'd0;
    localparam t_op OP_PUSH_TASK  = 3'd1;
    localparam t_op OP_POP        = 3'd2;
    localparam t_op OP_FLUSH      = 3'd3;
    localparam t_op OP_TASK_EXIT  = 3'd4;
    localparam t_op OP_SET_FOCUS  = 3'd5;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

endpackage

// ===== hdl/ptiqr_if.sv =====
// ----------------------------------------------------------------------------
// ptiqr_if
// Valid/ready channels of the task input queue router: request and result.
// ----------------------------------------------------------------------------
interface ptiqr_in_if
    import ptiqr_pkg::*;
();
    logic  valid;
    logic  ready;
    t_op   op;
    t_task task_req;
    t_byte data_byte;

    modport source (output valid, output op, output task_req, output data_byte,
                    input ready);
    modport sink   (input valid, input op, input task_req, input data_byte,
                    output ready);
endinterface

interface ptiqr_out_if
    import ptiqr_pkg::*;
();
    logic    valid;
    logic    ready;
    t_status status;
    t_byte   read_byte;
    t_task   focused_task;

    modport source (output valid, output status, output read_byte,
                    output focused_task, input ready);
    modport sink   (input valid, input status, input read_byte,
                    input focused_task, output ready);
endinterface

// ===== hdl/per_task_input_queue_router.sv =====
// ----------------------------------------------------------------------------
// per_task_input_queue_router
// One circular byte queue per task slot plus a focus register; push, pop,
// flush, task exit and set focus, one result per request.
// ----------------------------------------------------------------------------
// The block takes one request in every cycle while its result register is
// free or being read, and gives its result in the register in the cycle after
// the transfer; the output register decouples the two sides, so a new request
// is taken in the same cycle that the pending result is taken. Head and tail
// pointers live in flip-flops and are updated at the request's transfer; the
// byte store is a memory of NUM_TASKS * 2**ceil(log2(QUEUE_DEPTH)) bytes
// with one write and one registered read port, and that registered read is
// why the result waits in the register. Reset clears all pointers, the focus,
// the desktop register and the result register; no clearing pass is needed
// since only written entries are popped.
module per_task_input_queue_router
    import ptiqr_pkg::*;
#(
    parameter int NUM_TASKS   = DEF_NUM_TASKS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_desktop_we,
    input  t_task         i_desktop_wdata,
    ptiqr_in_if.sink      i_in,
    ptiqr_out_if.source   o_out
);

    localparam int SW    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int MEM_D = NUM_TASKS << PW;

    typedef logic [SW-1:0] t_slot;
    typedef logic [PW-1:0] t_ptr;

    // pointer flops
    t_ptr    r_head [NUM_TASKS];
    t_ptr    r_tail [NUM_TASKS];
    t_task   r_focus;
    t_task   r_desktop;

    // byte store
    t_byte   r_store [MEM_D];
    t_byte   r_rd_q;

    // result register
    logic    r_out_valid;
    t_status r_status;
    logic    r_pop_ok;

    logic    xfer;
    logic    req_ok;
    t_slot   req_slot;
    t_slot   sel_slot;
    t_ptr    sel_head;
    t_ptr    sel_tail;
    t_ptr    tail_nx;
    t_ptr    head_nx;
    logic    is_full;
    logic    is_empty;

    logic    push_en;
    logic    pop_en;
    logic    flush_en;
    logic    head_we;
    t_ptr    head_wval;
    t_task   n_focus;
    t_status n_status;

    assign xfer     = i_in.valid && i_in.ready;
    assign req_ok   = 32'(i_in.task_req) < NUM_TASKS;
    assign req_slot = SW'(i_in.task_req);
    // focus is always a valid slot: it is only loaded from checked values
    assign sel_slot = (i_in.op == OP_PUSH_FOCUS) ? SW'(r_focus) : req_slot;
    assign sel_head = r_head[sel_slot];
    assign sel_tail = r_tail[sel_slot];
    assign tail_nx  = (sel_tail == t_ptr'(QUEUE_DEPTH - 1)) ? '0 : sel_tail + t_ptr'(1);
    assign head_nx  = (sel_head == t_ptr'(QUEUE_DEPTH - 1)) ? '0 : sel_head + t_ptr'(1);
    assign is_full  = (tail_nx == sel_head);
    assign is_empty = (sel_head == sel_tail);

    always_comb begin
        push_en  = 1'b0;
        pop_en   = 1'b0;
        flush_en = 1'b0;
        n_focus  = r_focus;
        n_status = ST_DONE;
        unique case (i_in.op) inside
            OP_PUSH_FOCUS, OP_PUSH_TASK: begin
                if (i_in.op == OP_PUSH_FOCUS || req_ok) begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        push_en = 1'b1;
                    end
                end
            end
            OP_POP: begin
                if (req_ok) begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        pop_en = 1'b1;
                    end
                end
            end
            OP_FLUSH: begin
                flush_en = req_ok;
            end
            OP_TASK_EXIT: begin
                flush_en = req_ok;
                if (req_ok && r_focus == i_in.task_req) begin
                    n_focus = r_desktop;
                end
            end
            OP_SET_FOCUS: begin
                if (req_ok) begin
                    n_focus = i_in.task_req;
                end
            end
            default: begin
            end
        endcase
    end

    assign head_we   = pop_en || flush_en;
    assign head_wval = pop_en ? head_nx : sel_tail;

    assign i_in.ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
            r_focus     <= '0;
            r_desktop   <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_DONE;
            r_pop_ok    <= 1'b0;
        end else begin
            if (i_desktop_we && 32'(i_desktop_wdata) < NUM_TASKS) begin
                r_desktop <= i_desktop_wdata;
            end
            if (xfer) begin
                if (push_en) begin
                    r_tail[sel_slot] <= tail_nx;
                end
                if (head_we) begin
                    r_head[sel_slot] <= head_wval;
                end
                r_focus  <= n_focus;
                r_status <= n_status;
                r_pop_ok <= pop_en;
            end
            if (xfer) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // store: write at tail on push, read at head on pop
    always_ff @(posedge i_clk) begin
        if (xfer && push_en) begin
            r_store[{sel_slot, sel_tail}] <= i_in.data_byte;
        end
        if (xfer && pop_en) begin
            r_rd_q <= r_store[{sel_slot, sel_head}];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.read_byte    = r_pop_ok ? r_rd_q : '0;
    assign o_out.focused_task = r_focus;

endmodule

// ===== sim/tb_per_task_input_queue_router.sv =====
// ----------------------------------------------------------------------------
// tb_per_task_input_queue_router
// Self-checking bench: directed and random push/pop/flush/exit/focus traffic
// against a behavioral model of the per-task queues, under several idle and
// back-pressure patterns and several desktop task settings.
// ----------------------------------------------------------------------------
module tb_per_task_input_queue_router;
    import ptiqr_pkg::*;

    localparam int NUM_TASKS   = DEF_NUM_TASKS;
    localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;

    // opcodes the block must ignore
    localparam t_op OP_RSVD6 = 3'd6;
    localparam t_op OP_RSVD7 = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct {
        t_op   op;
        t_task slot;
        t_byte data;
    } t_request;

    typedef struct {
        t_status status;
        t_byte   read_byte;
        t_task   focused_task;
    } t_result;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_desktop_we;
    t_task i_desktop_wdata;

    ptiqr_in_if  in_if ();
    ptiqr_out_if out_if ();

    per_task_input_queue_router #(
        .NUM_TASKS   (NUM_TASKS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_desktop_we    (i_desktop_we),
        .i_desktop_wdata (i_desktop_wdata),
        .i_in            (in_if),
        .o_out           (out_if)
    );

    always #5 i_clk = ~i_clk;

    // model state
    t_byte queue_mem [NUM_TASKS][QUEUE_DEPTH];
    int    head_ptr  [NUM_TASKS];
    int    tail_ptr  [NUM_TASKS];
    t_task model_focus   = '0;
    t_task model_desktop = '0;

    t_request   request_queue[$];
    t_result    due_results[$];
    int         n_issued  = 0;
    int         n_retired = 0;
    int         errors    = 0;
    bit         in_taken  = 1'b0;
    t_idle_mode idle_mode = IDLE_NONE;

    // generator-side guesses, only used to aim exits at the focused slot
    t_task gen_focus   = '0;
    t_task gen_desktop = '0;

    function automatic int next_ptr(int p);
        return (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
    endfunction

    // one slot is always kept free, so full means next(tail) == head
    function automatic t_status queue_push(int s, t_byte b);
        if (next_ptr(tail_ptr[s]) == head_ptr[s])
            return ST_FULL;
        queue_mem[s][tail_ptr[s]] = b;
        tail_ptr[s] = next_ptr(tail_ptr[s]);
        return ST_DONE;
    endfunction

    function automatic t_result route_request(t_request r);
        t_result res;
        int      s;
        res.status    = ST_DONE;
        res.read_byte = '0;
        s = int'(r.slot);
        case (r.op)
            OP_PUSH_FOCUS: res.status = queue_push(int'(model_focus), r.data);
            OP_PUSH_TASK:  res.status = queue_push(s, r.data);
            OP_POP: begin
                if (head_ptr[s] == tail_ptr[s]) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_byte = queue_mem[s][head_ptr[s]];
                    head_ptr[s] = next_ptr(head_ptr[s]);
                end
            end
            OP_FLUSH: head_ptr[s] = tail_ptr[s];
            OP_TASK_EXIT: begin
                head_ptr[s] = tail_ptr[s];
                if (model_focus == r.slot)
                    model_focus = model_desktop;
            end
            OP_SET_FOCUS: model_focus = r.slot;
            default: ;
        endcase
        res.focused_task = model_focus;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: model update and result check at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_desktop_we && int'(i_desktop_wdata) < NUM_TASKS)
                model_desktop = i_desktop_wdata;
            if (in_if.valid && in_if.ready) begin
                in_taken = 1'b1;
                due_results.push_back(route_request('{in_if.op, in_if.task_req,
                                                      in_if.data_byte}));
            end
            if (out_if.valid && out_if.ready) begin
                got.status       = out_if.status;
                got.read_byte    = out_if.read_byte;
                got.focused_task = out_if.focused_task;
                if (due_results.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result: status %0d byte %02h focus %0d",
                                 got.status, got.read_byte, got.focused_task);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    n_retired++;
                    if (got.status !== want.status || got.read_byte !== want.read_byte ||
                        got.focused_task !== want.focused_task) begin
                        if (errors < 10) begin
                            $display("mismatch on result %0d: expected status %0d byte %02h focus %0d",
                                     n_retired, want.status, want.read_byte,
                                     want.focused_task);
                            $display("    got status %0d byte %02h focus %0d",
                                     got.status, got.read_byte, got.focused_task);
                        end
                        errors++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: request side and result back-pressure, changed at falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_request r;
        bit       gap;
        bit       stall;
        gap   = ((idle_mode == IDLE_SENDER)   && $urandom_range(99) < 58) ||
                ((idle_mode == IDLE_BOTH)     && $urandom_range(99) < 7);
        stall = ((idle_mode == IDLE_RECEIVER) && $urandom_range(99) < 58) ||
                ((idle_mode == IDLE_BOTH)     && $urandom_range(99) < 7);
        if (i_rst_n) begin
            if (!in_if.valid || in_taken) begin
                if (request_queue.size() != 0 && !gap) begin
                    r = request_queue.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.op        <= r.op;
                    in_if.task_req  <= r.slot;
                    in_if.data_byte <= r.data;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            out_if.ready <= !stall;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic add_request(t_op op, t_task slot, t_byte data);
        request_queue.push_back('{op, slot, data});
        n_issued++;
        if (op == OP_SET_FOCUS)
            gen_focus = slot;
        else if (op == OP_TASK_EXIT && slot == gen_focus)
            gen_focus = gen_desktop;
    endtask

    // every issued item has come back and the block is quiet
    task automatic wait_drained();
        while (n_retired != n_issued)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_desktop(t_task v);
        @(negedge i_clk);
        i_desktop_we    <= 1'b1;
        i_desktop_wdata <= v;
        gen_desktop = v;
        @(negedge i_clk);
        i_desktop_we    <= 1'b0;
    endtask

    function automatic t_task pick_slot();
        // most traffic on a few slots so pointers wrap and queues fill
        return ($urandom_range(99) < 75) ? t_task'($urandom_range(3))
                                         : t_task'($urandom_range(NUM_TASKS - 1));
    endfunction

    task automatic add_random(int count);
        int    done;
        int    pick;
        int    n;
        t_task s;
        t_op   op;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
                // push QUEUE_DEPTH-4 to QUEUE_DEPTH+6 bytes into one queue, often past full, then drain past empty
                s = pick_slot();
                n = $urandom_range(QUEUE_DEPTH + 6, QUEUE_DEPTH - 4);
                for (int k = 0; k < n; k++)
                    add_request(OP_PUSH_TASK, s, t_byte'($urandom_range(255)));
                for (int k = 0; k < n + 2; k++)
                    add_request(OP_POP, s, t_byte'($urandom_range(255)));
                done += 2 * n + 2;
            end else begin
                pick = $urandom_range(99);
                s    = pick_slot();
                if (pick < 20)       op = OP_PUSH_FOCUS;
                else if (pick < 45)  op = OP_PUSH_TASK;
                else if (pick < 72)  op = OP_POP;
                else if (pick < 77)  op = OP_FLUSH;
                else if (pick < 85)  op = OP_TASK_EXIT;
                else if (pick < 95)  op = OP_SET_FOCUS;
                else if (pick < 97)  op = OP_RSVD6;
                else                 op = OP_RSVD7;
                if (op == OP_TASK_EXIT && $urandom_range(1) == 1)
                    s = gen_focus;
                add_request(op, s, t_byte'($urandom_range(255)));
                done++;
            end
        end
    endtask

    initial begin
        t_task phase_desktop [4];
        i_rst_n         = 1'b0;
        i_desktop_we    = 1'b0;
        i_desktop_wdata = '0;
        in_if.valid     = 1'b0;
        in_if.op        = OP_PUSH_FOCUS;
        in_if.task_req  = '0;
        in_if.data_byte = '0;
        out_if.ready    = 1'b0;
        for (int s = 0; s < NUM_TASKS; s++) begin
            head_ptr[s] = 0;
            tail_ptr[s] = 0;
            for (int k = 0; k < QUEUE_DEPTH; k++)
                queue_mem[s][k] = '0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pop, byte extremes, flush, exits, ignored opcodes
        add_request(OP_TASK_EXIT,  4'd0,  8'h00);   // focused exit with reset desktop
        add_request(OP_POP,        4'd0,  8'h00);
        add_request(OP_PUSH_FOCUS, 4'd0,  8'h00);
        add_request(OP_PUSH_FOCUS, 4'd0,  8'hFF);
        add_request(OP_POP,        4'd0,  8'h00);
        add_request(OP_POP,        4'd0,  8'hFF);
        add_request(OP_POP,        4'd0,  8'h00);
        add_request(OP_SET_FOCUS,  4'd15, 8'h00);
        add_request(OP_PUSH_FOCUS, 4'd0,  8'hA5);
        add_request(OP_PUSH_TASK,  4'd15, 8'h5A);
        add_request(OP_POP,        4'd15, 8'hFF);
        add_request(OP_FLUSH,      4'd15, 8'h00);
        add_request(OP_POP,        4'd15, 8'h00);
        add_request(OP_PUSH_TASK,  4'd3,  8'h3C);
        add_request(OP_TASK_EXIT,  4'd3,  8'h00);   // not focused, focus stays
        add_request(OP_POP,        4'd3,  8'h00);
        add_request(OP_RSVD6,      4'd7,  8'h81);
        add_request(OP_RSVD7,      4'd15, 8'h7E);
        wait_drained();
        write_desktop(4'd9);
        add_request(OP_TASK_EXIT,  4'd15, 8'h00);   // focused, moves to desktop
        add_request(OP_PUSH_FOCUS, 4'd0,  8'h11);
        add_request(OP_POP,        4'd9,  8'hFF);

        phase_desktop[0] = 4'd0;
        phase_desktop[1] = 4'd15;
        phase_desktop[2] = t_task'($urandom_range(NUM_TASKS - 1));
        phase_desktop[3] = 4'd5;
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            idle_mode = t_idle_mode'(p);
            write_desktop(phase_desktop[p]);
            if (p == 2) begin
                // sender holds off until the pipeline is empty
                add_random(85);
                wait_drained();
                add_random(85);
            end else begin
                add_random(170);
            end
        end

        wait_drained();
        repeat (5) @(negedge i_clk);
        if (errors == 0 && due_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule
